/* hdl/assert_macros.svh */
// Assertion helpers used by the top-level RTL; clocked on i_clk, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SFV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SFV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

/* hdl/sfv_pkg.sv */
package sfv_pkg;

    localparam int SFV_HISTORY_DEPTH = 16;
    localparam int SFV_QUEUE_DEPTH   = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AGREE_TEMP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AGREE_HUM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_MASK   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BUSY_MASK  = 3'd5;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    localparam logic signed [19:0] TEMP_OFFSET = 20'sd51200;

    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 40;
    localparam int OUT_USER_W  = 2;

    typedef enum logic [1:0] {
        VERDICT_DROP    = 2'd0,
        VERDICT_CONFIRM = 2'd1,
        VERDICT_USE     = 2'd2
    } t_verdict;

    typedef logic signed [18:0] t_temp;
    typedef logic [16:0]        t_hum;

    typedef struct packed {
        t_temp       min_temp;
        t_temp       max_temp;
        logic [17:0] agree_temp;
        logic [16:0] agree_hum;
        logic [7:0]  cal_mask;
        logic [7:0]  busy_mask;
    } t_sfv_cfg;

    typedef struct packed {
        t_temp temp;
        t_hum  hum;
        logic  crc_ok;
        logic  sound;
        logic  busy;
    } t_sfv_item;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_sfv_qstat;

    // One byte through the CRC-8 register, MSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* hdl/sfv_front.sv */
module sfv_front (
    input  sfv_pkg::t_sfv_cfg                 i_cfg,
    input  logic [sfv_pkg::IN_DATA_W-1:0]     i_frame,
    output sfv_pkg::t_sfv_item                o_item
);
    import sfv_pkg::*;

    logic [7:0]         b0, b1, b2, b3, b4, b5, b6;
    logic [7:0]         crc;
    logic [19:0]        raw_h, raw_t;
    logic [24:0]        scaled_h, scaled_t;
    logic signed [19:0] temp_wide;
    t_temp              temp;
    logic               crc_ok, calibrated, in_range;

    assign b0 = i_frame[7:0];
    assign b1 = i_frame[15:8];
    assign b2 = i_frame[23:16];
    assign b3 = i_frame[31:24];
    assign b4 = i_frame[39:32];
    assign b5 = i_frame[47:40];
    assign b6 = i_frame[55:48];

    always_comb begin
        crc = CRC_INIT;
        crc = crc8_byte(crc, b0);
        crc = crc8_byte(crc, b1);
        crc = crc8_byte(crc, b2);
        crc = crc8_byte(crc, b3);
        crc = crc8_byte(crc, b4);
        crc = crc8_byte(crc, b5);
    end

    assign raw_h = {b1, b2, b3[7:4]};
    assign raw_t = {b3[3:0], b4, b5};

    // x * 25 as shift-and-add
    assign scaled_h = ({5'b0, raw_h} << 4) + ({5'b0, raw_h} << 3) + {5'b0, raw_h};
    assign scaled_t = ({5'b0, raw_t} << 4) + ({5'b0, raw_t} << 3) + {5'b0, raw_t};

    assign temp_wide = $signed({2'b0, scaled_t[24:7]}) - TEMP_OFFSET;
    assign temp      = temp_wide[18:0];

    assign crc_ok     = (crc == b6);
    assign calibrated = |(b0 & i_cfg.cal_mask);
    assign in_range   = (temp >= $signed(i_cfg.min_temp)) && (temp <= $signed(i_cfg.max_temp));

    always_comb begin
        o_item.temp   = temp;
        o_item.hum    = scaled_h[24:8];
        o_item.crc_ok = crc_ok;
        o_item.sound  = crc_ok && calibrated && in_range;
        o_item.busy   = |(b0 & i_cfg.busy_mask);
    end

endmodule

/* hdl/sfv_queue.sv */
module sfv_queue #(
    parameter int DEPTH = sfv_pkg::SFV_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sfv_pkg::t_sfv_item  i_item,
    input  logic                i_pop,
    output sfv_pkg::t_sfv_item  o_head,
    output sfv_pkg::t_sfv_qstat o_stat
);
    import sfv_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_sfv_item        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head           = r_mem[r_rd_ptr];
    assign o_stat.not_empty = (r_count != '0);
    assign o_stat.full      = (r_count == CNT_W'(DEPTH));

endmodule

/* hdl/sfv_back.sv */
module sfv_back #(
    parameter int HISTORY_DEPTH = sfv_pkg::SFV_HISTORY_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sfv_pkg::t_sfv_cfg                  i_cfg,
    input  sfv_pkg::t_sfv_item                 i_item,
    input  sfv_pkg::t_sfv_qstat                i_qstat,
    output logic                               o_pop,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [sfv_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    output logic [sfv_pkg::OUT_USER_W-1:0]     o_m_tuser
);
    import sfv_pkg::*;

    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

    logic [HISTORY_DEPTH-1:0] r_hist, n_hist;
    logic [CNT_W-1:0]         r_bad, n_bad;
    logic [CNT_W-1:0]         r_seen, n_seen;
    logic                     r_prev_good;
    t_temp                    r_prev_temp;
    t_hum                     r_prev_hum;
    logic                     r_m_valid;
    logic [OUT_DATA_W-1:0]    r_m_data;
    t_verdict                 r_m_verdict;

    logic                     fail, drop_now, agrees, trusted;
    logic signed [19:0]       dt;
    logic signed [17:0]       dh;
    logic [19:0]              abs_dt;
    logic [17:0]              abs_dh;
    t_verdict                 verdict;
    t_temp                    out_temp;
    t_hum                     out_hum;

    assign o_pop = i_qstat.not_empty && (!r_m_valid || i_m_tready);

    always_comb begin
        fail   = !i_item.sound;
        n_hist = (r_hist << 1) | HISTORY_DEPTH'(fail);
        // the bit leaving the window is zero until the window has filled
        n_bad  = r_bad + CNT_W'(fail) - CNT_W'(r_hist[HISTORY_DEPTH-1]);
        n_seen = (r_seen == CNT_W'(HISTORY_DEPTH)) ? r_seen : r_seen + 1'b1;
        trusted = ({n_bad, 1'b0} <= {1'b0, n_seen});

        dt     = 20'(i_item.temp) - 20'(r_prev_temp);
        dh     = $signed({1'b0, i_item.hum}) - $signed({1'b0, r_prev_hum});
        abs_dt = dt[19] ? 20'(-dt) : 20'(dt);
        abs_dh = dh[17] ? 18'(-dh) : 18'(dh);
        agrees = r_prev_good && (abs_dt <= {2'b0, i_cfg.agree_temp})
                             && (abs_dh <= {1'b0, i_cfg.agree_hum});

        drop_now = fail || i_item.busy;
        if (drop_now || !trusted) begin
            verdict = VERDICT_DROP;
        end else if (!agrees) begin
            verdict = VERDICT_CONFIRM;
        end else begin
            verdict = VERDICT_USE;
        end
        out_temp = (verdict == VERDICT_USE) ? i_item.temp : '0;
        out_hum  = (verdict == VERDICT_USE) ? i_item.hum  : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist      <= '0;
            r_bad       <= '0;
            r_seen      <= '0;
            r_prev_good <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_hist      <= n_hist;
                r_bad       <= n_bad;
                r_seen      <= n_seen;
                r_prev_good <= !drop_now;
                r_m_valid   <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (!drop_now) begin
                r_prev_temp <= i_item.temp;
                r_prev_hum  <= i_item.hum;
            end
            r_m_verdict <= verdict;
            r_m_data    <= {2'b0, trusted, i_item.crc_ok, out_hum, out_temp};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_verdict;

endmodule

/* hdl/sensor_frame_vetter.sv */
// Sensor frame vetter.
// Input stream: one seven-byte sensor frame per request on i_s_tdata (byte 0 in
// the low bits). The frame is checked (CRC-8, calibrated bit, temperature range),
// its failure is logged in a sliding history window, and a verdict is issued.
// Output stream: one result per frame; o_m_tuser carries the verdict (drop,
// confirm, use), o_m_tdata the readings (zero unless use) and two status flags.
// Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is high;
// only while no frame is in flight.
// An accepted frame is classified into the queue, then decided into the output
// register that drives o_m_tvalid. The block takes one frame per cycle while
// the receiver accepts results; the decision step updates the history and
// the previous-frame record as each frame leaves the queue.
// When the receiver stalls the result holds in the output register and the
// two-entry queue keeps taking frames until it fills, then o_s_tready drops.
// Reset (synchronous, active low) empties the queue and output, clears the
// history and the previous-frame flag, and restores the register defaults.
module sensor_frame_vetter #(
    parameter int HISTORY_DEPTH = sfv_pkg::SFV_HISTORY_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // status_byte, hum_high, hum_mid, shared_nibbles, temp_mid, temp_low, check_byte
    input  logic [sfv_pkg::IN_DATA_W-1:0]      i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // temperature[18:0], humidity[35:19], crc_good[36], trusted[37], zero pad
    output logic [sfv_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    // verdict[1:0]
    output logic [sfv_pkg::OUT_USER_W-1:0]     o_m_tuser,
    input  logic                               i_cfg_we,
    input  logic [sfv_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sfv_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import sfv_pkg::*;

    `include "assert_macros.svh"

    t_sfv_cfg   r_cfg;
    t_sfv_item  w_front_item, w_head;
    t_sfv_qstat w_qstat;
    logic       w_push, w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_temp   <= -19'sd40960;
            r_cfg.max_temp   <= 19'sd122880;
            r_cfg.agree_temp <= 18'd2048;
            r_cfg.agree_hum  <= 17'd5120;
            r_cfg.cal_mask   <= 8'h08;
            r_cfg.busy_mask  <= 8'h80;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_TEMP:   r_cfg.min_temp   <= i_cfg_data;
                CFG_MAX_TEMP:   r_cfg.max_temp   <= i_cfg_data;
                CFG_AGREE_TEMP: r_cfg.agree_temp <= i_cfg_data[17:0];
                CFG_AGREE_HUM:  r_cfg.agree_hum  <= i_cfg_data[16:0];
                CFG_CAL_MASK:   r_cfg.cal_mask   <= i_cfg_data[7:0];
                CFG_BUSY_MASK:  r_cfg.busy_mask  <= i_cfg_data[7:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    assign o_s_tready = !w_qstat.full;
    assign w_push     = i_s_tvalid && o_s_tready;

    sfv_front u_front (
        .i_cfg   (r_cfg),
        .i_frame (i_s_tdata),
        .o_item  (w_front_item)
    );

    sfv_queue #(
        .DEPTH (SFV_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    sfv_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_item     (w_head),
        .i_qstat    (w_qstat),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    `SFV_ASSERT_NOW(a_readings_zero_unless_use, o_m_tvalid && (o_m_tuser != VERDICT_USE), o_m_tdata[35:0] == '0, "readings present without use verdict")
    `SFV_ASSERT_NOW(a_use_needs_crc_and_trust, o_m_tvalid && (o_m_tuser == VERDICT_USE), o_m_tdata[36] && o_m_tdata[37], "use verdict without good CRC and trust")
    `SFV_ASSERT_NEXT(a_idle_latency, w_push && !w_qstat.not_empty && !o_m_tvalid, ##1 o_m_tvalid, "result missing two cycles after request into idle block")
    `SFV_ASSERT_NOW(a_pop_only_when_queued, w_pop, w_qstat.not_empty, "queue popped while empty")

endmodule
